[design/tvbs_pkg.sv]
// package for the torque vectoring bilinear split block
// item types and fixed-point constants, used by the core and the checker
`timescale 1ns / 1ps

package tvbs_pkg;

  localparam int ANGLE_POINTS_DEF    = 16;
  localparam int THROTTLE_POINTS_DEF = 16;
  localparam int BIAS_W              = 16;
  localparam logic [15:0] BIAS_ONE   = 16'd32768;
  localparam logic [15:0] TORQUE_MAX = 16'd65535;

  localparam logic [15:0] RST_THROTTLE_GAIN = 16'd3840;
  localparam logic [15:0] RST_ANGLE_OFFSET  = 16'd23040;
  localparam logic [15:0] RST_ANGLE_GAIN    = 16'd2048;
  localparam logic [15:0] RST_FRONT_BIAS    = 16'd16384;

  typedef enum logic [1:0] {
    REG_THROTTLE_GAIN = 2'd0,
    REG_ANGLE_OFFSET  = 2'd1,
    REG_ANGLE_GAIN    = 2'd2,
    REG_FRONT_BIAS    = 2'd3
  } reg_index_t;

  typedef enum logic {
    FUNC_COMPUTE = 1'b0,
    FUNC_WRITE   = 1'b1
  } func_t;

  typedef struct packed {
    logic               func;
    logic [15:0]        throttle;
    logic signed [15:0] steer_angle;
    logic               angle_valid;
    logic [15:0]        torque_limit;
    logic [3:0]         entry_row;
    logic [3:0]         entry_col;
    logic [15:0]        entry_value;
  } in_item_t;

  typedef struct packed {
    logic        valid_res;
    logic [15:0] torque_rear_left;
    logic [15:0] torque_rear_right;
    logic [15:0] torque_front_left;
    logic [15:0] torque_front_right;
  } out_item_t;

endpackage

[design/torque_vector_bilinear_split_core.sv]
// throughput: one item per cycle; the whole pipeline stalls together while
// a result waits at the output register
// the four table corners come from four copies of the bias table, one read port each
// reset (synchronous rst) clears stage valid bits and resets config registers to their defaults; table is unset
`timescale 1ns / 1ps

module torque_vector_bilinear_split_core
  import tvbs_pkg::*;
#(
  parameter int ANGLE_POINTS    = ANGLE_POINTS_DEF,
  parameter int THROTTLE_POINTS = THROTTLE_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW    = $clog2(ANGLE_POINTS);
  localparam int TW    = $clog2(THROTTLE_POINTS);
  localparam int DEPTH = ANGLE_POINTS * THROTTLE_POINTS;
  localparam int ADW   = $clog2(DEPTH);
  localparam logic [15:0] TOP_T = 16'((THROTTLE_POINTS - 1) * 256);
  localparam logic [15:0] TOP_A = 16'((ANGLE_POINTS - 1) * 256);

  logic [15:0] throttle_gain, angle_offset, angle_gain, front_bias;
  logic        en;

  // configuration
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_gain <= RST_THROTTLE_GAIN;
      angle_offset  <= RST_ANGLE_OFFSET;
      angle_gain    <= RST_ANGLE_GAIN;
      front_bias    <= RST_FRONT_BIAS;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_THROTTLE_GAIN: throttle_gain <= cfg_data;
        REG_ANGLE_OFFSET:  angle_offset  <= cfg_data;
        REG_ANGLE_GAIN:    angle_gain    <= cfg_data;
        REG_FRONT_BIAS:    front_bias    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic s1_v, s2_v, s3_v, s4_v, s5_v, s6_v;
  assign en       = !s6_v || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      {s1_v, s2_v, s3_v, s4_v, s5_v, s6_v} <= '0;
    end else if (en) begin
      {s1_v, s2_v, s3_v, s4_v, s5_v, s6_v} <= {in_valid, s1_v, s2_v, s3_v, s4_v, s5_v};
    end
  end

  // stage 1: index products
  logic signed [16:0] angle_sum;
  in_item_t           s1_item;
  logic [31:0]        s1_tprod, s1_aprod;
  logic               s1_apos;

  assign angle_sum = 17'(in_item.steer_angle) + 17'(signed'(angle_offset));

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item  <= in_item;
      s1_tprod <= in_item.throttle * throttle_gain;
      s1_aprod <= angle_sum[15:0] * angle_gain;
      s1_apos  <= angle_sum > 17'sd0;
    end
  end

  // stage 2: clamp, corner addresses, table read and write
  logic [15:0]    ti, ai, ti_raw, ai_raw;
  logic [TW-1:0]  t1, t2;
  logic [AW-1:0]  a1, a2;
  logic [ADW-1:0] addr00, addr01, addr10, addr11, waddr;
  logic           we;
  logic [15:0]    wdata;

  assign ti_raw = s1_tprod[31:16];
  assign ai_raw = s1_apos ? s1_aprod[31:16] : 16'd0;
  assign ti     = (ti_raw > TOP_T) ? TOP_T : ti_raw;
  assign ai     = (ai_raw > TOP_A) ? TOP_A : ai_raw;
  assign t1     = ti[8 +: TW];
  assign a1     = ai[8 +: AW];
  assign t2     = t1 + TW'(ti[7:0] != 8'd0);
  assign a2     = a1 + AW'(ai[7:0] != 8'd0);
  assign addr00 = ADW'(a1) * ADW'(THROTTLE_POINTS) + ADW'(t1);
  assign addr01 = ADW'(a1) * ADW'(THROTTLE_POINTS) + ADW'(t2);
  assign addr10 = ADW'(a2) * ADW'(THROTTLE_POINTS) + ADW'(t1);
  assign addr11 = ADW'(a2) * ADW'(THROTTLE_POINTS) + ADW'(t2);

  assign we = en && s1_v && (s1_item.func == FUNC_WRITE)
              && (32'(s1_item.entry_row) < ANGLE_POINTS)
              && (32'(s1_item.entry_col) < THROTTLE_POINTS);
  assign waddr = ADW'(s1_item.entry_row) * ADW'(THROTTLE_POINTS) + ADW'(s1_item.entry_col);
  assign wdata = (s1_item.entry_value > BIAS_ONE) ? BIAS_ONE : s1_item.entry_value;

  logic [15:0] c00, c01, c10, c11;

  tvbs_ram #(.WIDTH(BIAS_W), .DEPTH(DEPTH)) u_ram00 (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(en), .raddr(addr00), .rdata(c00));
  tvbs_ram #(.WIDTH(BIAS_W), .DEPTH(DEPTH)) u_ram01 (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(en), .raddr(addr01), .rdata(c01));
  tvbs_ram #(.WIDTH(BIAS_W), .DEPTH(DEPTH)) u_ram10 (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(en), .raddr(addr10), .rdata(c10));
  tvbs_ram #(.WIDTH(BIAS_W), .DEPTH(DEPTH)) u_ram11 (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(en), .raddr(addr11), .rdata(c11));

  logic        s2_wr, s2_av, s3_wr, s3_av, s4_wr, s4_av, s5_wr, s5_av;
  logic [15:0] s2_lim, s3_lim, s4_lim, s5_lim;
  logic [7:0]  s2_ft, s2_fa, s3_fa;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_wr  <= s1_item.func == FUNC_WRITE;
      s2_av  <= s1_item.angle_valid;
      s2_lim <= s1_item.torque_limit;
      s2_ft  <= ti[7:0];
      s2_fa  <= ai[7:0];
    end
  end

  // stage 3: blend along throttle
  logic [8:0]  wt0, wa0;
  logic [24:0] s3_r1, s3_r2;

  assign wt0 = 9'd256 - 9'(s2_ft);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r1  <= 25'(c00 * wt0) + 25'(c01 * s2_ft);
      s3_r2  <= 25'(c10 * wt0) + 25'(c11 * s2_ft);
      s3_fa  <= s2_fa;
      s3_wr  <= s2_wr;
      s3_av  <= s2_av;
      s3_lim <= s2_lim;
    end
  end

  // stage 4: blend along angle
  logic [32:0] s4_r;

  assign wa0 = 9'd256 - 9'(s3_fa);

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r   <= 33'(s3_r1 * wa0) + 33'(s3_r2 * s3_fa);
      s4_wr  <= s3_wr;
      s4_av  <= s3_av;
      s4_lim <= s3_lim;
    end
  end

  // stage 5: round bias, axle products
  logic [32:0] r_rnd;
  logic [16:0] right_raw;
  logic [15:0] right, left, front, rear;
  logic [30:0] s5_rr, s5_lr, s5_rf, s5_lf;

  assign r_rnd     = s4_r + 33'd32768;
  assign right_raw = r_rnd[32:16];
  assign right     = (right_raw > 17'(BIAS_ONE)) ? BIAS_ONE : right_raw[15:0];
  assign left      = BIAS_ONE - right;
  assign front     = (front_bias > BIAS_ONE) ? BIAS_ONE : front_bias;
  assign rear      = BIAS_ONE - front;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_rr  <= 31'(right * rear);
      s5_lr  <= 31'(left * rear);
      s5_rf  <= 31'(right * front);
      s5_lf  <= 31'(left * front);
      s5_wr  <= s4_wr;
      s5_av  <= s4_av;
      s5_lim <= s4_lim;
    end
  end

  // stage 6: limit product, round, saturate
  function automatic logic [15:0] scale_sat(input logic [30:0] p, input logic [15:0] lim);
    logic [46:0] prod;
    logic [16:0] q;
    prod = 47'(p * lim) + 47'(1 << 29);
    q    = (prod[46:30] > 17'(TORQUE_MAX)) ? 17'(TORQUE_MAX) : prod[46:30];
    return q[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      if (s5_wr) begin
        out_item <= '0;
      end else begin
        out_item.valid_res          <= s5_av;
        out_item.torque_rear_left   <= scale_sat(s5_rr, s5_lim);
        out_item.torque_rear_right  <= scale_sat(s5_lr, s5_lim);
        out_item.torque_front_left  <= scale_sat(s5_rf, s5_lim);
        out_item.torque_front_right <= scale_sat(s5_lf, s5_lim);
      end
    end
  end

  assign out_valid = s6_v;

endmodule

[design/tvbs_ram.sv]
// generic single write port ram with registered read and read enable
// no dependencies
`timescale 1ns / 1ps

module tvbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/tvbs_checker.sv]
// port-level checks for torque_vector_bilinear_split_core
// uses tvbs_pkg; bound to the top level below
`timescale 1ns / 1ps

module tvbs_checker
  import tvbs_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without output stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind torque_vector_bilinear_split_core tvbs_checker u_tvbs_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item));

[sim/tb_top.sv]
// testbench for torque_vector_bilinear_split_core: directed and random items
// checked against a behavioral predictor; depends on tvbs_pkg and the core
`timescale 1ns / 1ps

module tb_top;
  import tvbs_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int IN_W = $bits(in_item_t);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  torque_vector_bilinear_split_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [15:0] bias_tab [0:255];
  logic [15:0] thr_gain, ang_off, ang_gain, front_cfg;
  out_item_t torque_q[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int cycles = 0;
  bit no_idle = 1'b0;

  function automatic logic [15:0] wheel_torque(logic [15:0] bias, logic [15:0] axle,
                                               logic [15:0] lim);
    logic [63:0] p;
    p = 64'(bias) * 64'(axle) * 64'(lim);
    p = (p + 64'(1 << 29)) >> 30;
    return (p > 64'd65535) ? 16'hffff : p[15:0];
  endfunction

  function automatic logic [15:0] entry_at(int a, int t);
    if (a > 15 || t > 15) return 16'd0;
    return bias_tab[a * 16 + t];
  endfunction

  function automatic out_item_t predict_split(in_item_t it);
    out_item_t r;
    int steer, off, sum;
    logic [63:0] ti, ai, r1, r2, acc;
    int t1, t2, a1, a2, ft, fa;
    logic [31:0] right, left, front, rear;
    r = '0;
    if (it.func == FUNC_WRITE) begin
      bias_tab[{it.entry_row, it.entry_col}] =
        (it.entry_value > BIAS_ONE) ? BIAS_ONE : it.entry_value;
      return r;
    end
    steer = $signed(it.steer_angle);
    off = $signed(ang_off);
    sum = steer + off;
    ti = (64'(it.throttle) * 64'(thr_gain)) >> 16;
    ai = (sum > 0) ? ((64'(sum) * 64'(ang_gain)) >> 16) : 64'd0;
    if (ti > 64'(15 << 8)) ti = 64'(15 << 8);
    if (ai > 64'(15 << 8)) ai = 64'(15 << 8);
    t1 = int'(ti >> 8); ft = int'(ti & 8'hff); t2 = t1 + (ft != 0);
    a1 = int'(ai >> 8); fa = int'(ai & 8'hff); a2 = a1 + (fa != 0);
    r1 = 64'(entry_at(a1, t1)) * (256 - ft) + 64'(entry_at(a1, t2)) * ft;
    r2 = 64'(entry_at(a2, t1)) * (256 - ft) + 64'(entry_at(a2, t2)) * ft;
    acc = r1 * (256 - fa) + r2 * fa;
    right = 32'((acc + 64'(1 << 15)) >> 16);
    if (right > 32768) right = 32768;
    left = 32768 - right;
    front = (front_cfg > BIAS_ONE) ? 32768 : 32'(front_cfg);
    rear = 32768 - front;
    r.valid_res = it.angle_valid;
    r.torque_rear_left = wheel_torque(right[15:0], rear[15:0], it.torque_limit);
    r.torque_rear_right = wheel_torque(left[15:0], rear[15:0], it.torque_limit);
    r.torque_front_left = wheel_torque(right[15:0], front[15:0], it.torque_limit);
    r.torque_front_right = wheel_torque(left[15:0], front[15:0], it.torque_limit);
    return r;
  endfunction

  // output side: random stall and result check
  always @(negedge clk) begin
    if (!rst) out_ready <= no_idle || ($urandom_range(0, 99) >= 7);
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      n_results <= n_results + 1;
      if (torque_q.size() == 0) begin
        $display("%0t unexpected item: got %h", $time, out_item);
        errors <= errors + 1;
      end else begin
        exp_r = torque_q.pop_front();
        if (out_item.valid_res !== exp_r.valid_res ||
            out_item.torque_rear_left !== exp_r.torque_rear_left ||
            out_item.torque_rear_right !== exp_r.torque_rear_right ||
            out_item.torque_front_left !== exp_r.torque_front_left ||
            out_item.torque_front_right !== exp_r.torque_front_right) begin
          $display("%0t mismatch: expected %h actual %h", $time, exp_r, out_item);
          errors <= errors + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // valid stays high after acceptance until the next item, an idle cycle or a drain
  task automatic send_item(in_item_t it);
    while (!no_idle && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    torque_q.push_back(predict_split(it));
    n_items++;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (torque_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_THROTTLE_GAIN: thr_gain = data;
      REG_ANGLE_OFFSET:  ang_off = data;
      REG_ANGLE_GAIN:    ang_gain = data;
      default:           front_cfg = data;
    endcase
  endtask

  function automatic in_item_t write_entry(int row, int col, logic [15:0] val);
    in_item_t it;
    it = in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
    it.func = FUNC_WRITE;
    it.entry_row = row[3:0];
    it.entry_col = col[3:0];
    it.entry_value = val;
    return it;
  endfunction

  function automatic in_item_t compute_item(logic [15:0] thr, logic [15:0] ang,
                                            logic av, logic [15:0] lim);
    in_item_t it;
    it = in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
    it.func = FUNC_COMPUTE;
    it.throttle = thr;
    it.steer_angle = ang;
    it.angle_valid = av;
    it.torque_limit = lim;
    return it;
  endfunction

  function automatic logic [15:0] rand_bias();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return BIAS_ONE;
      2: return 16'(($urandom_range(32769, 65535)));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  // fill the whole table so no unwritten entry is ever read
  task automatic test_table_fill();
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++)
        send_item(write_entry(r, c, rand_bias()));
  endtask

  task automatic test_directed();
    send_item(compute_item(16'h0000, 16'sh8000, 1'b1, 16'hffff));
    send_item(compute_item(16'hffff, 16'sh7fff, 1'b0, 16'hffff));
    send_item(compute_item(16'h8000, 16'h0000, 1'b1, 16'h0000));
    send_item(compute_item(16'h1000, 16'h0100, 1'b1, 16'd1));
    send_item(write_entry(0, 0, 16'hffff));
    send_item(write_entry(15, 15, 16'h8001));
    send_item(write_entry(5, 5, 16'd0));
    send_item(compute_item(16'h0000, 16'sha600, 1'b1, 16'hffff));
    send_item(compute_item(16'hffff, 16'sh7fff, 1'b1, 16'h8000));
    drain();
    write_reg(REG_FRONT_BIAS, 16'hffff);
    send_item(compute_item(16'h4444, 16'h0280, 1'b1, 16'hffff));
    drain();
    write_reg(REG_FRONT_BIAS, 16'd0);
    write_reg(REG_THROTTLE_GAIN, 16'hffff);
    write_reg(REG_ANGLE_GAIN, 16'hffff);
    write_reg(REG_ANGLE_OFFSET, 16'sh8000);
    send_item(compute_item(16'hffff, 16'sh7fff, 1'b1, 16'hffff));
    send_item(compute_item(16'h0001, 16'sh8000, 1'b0, 16'hffff));
    drain();
    write_reg(REG_THROTTLE_GAIN, 16'd0);
    write_reg(REG_ANGLE_GAIN, 16'd0);
    write_reg(REG_ANGLE_OFFSET, 16'sh7fff);
    send_item(compute_item(16'hffff, 16'sh7fff, 1'b1, 16'hffff));
    drain();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 250 == 0) begin
        drain();
        write_reg(REG_THROTTLE_GAIN, 16'($urandom));
        write_reg(REG_ANGLE_OFFSET, 16'($urandom));
        write_reg(REG_ANGLE_GAIN, 16'($urandom_range(0, 8192)));
        write_reg(REG_FRONT_BIAS, rand_bias());
      end
      no_idle = (i >= 500 && i < 650);
      if ($urandom_range(0, 9) < 2)
        send_item(write_entry($urandom_range(0, 15), $urandom_range(0, 15), rand_bias()));
      else
        send_item(compute_item(16'($urandom), 16'($urandom), 1'($urandom),
                               ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom)));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    thr_gain = RST_THROTTLE_GAIN;
    ang_off = RST_ANGLE_OFFSET;
    ang_gain = RST_ANGLE_GAIN;
    front_cfg = RST_FRONT_BIAS;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_table_fill();
    test_directed();
    test_random(730);
    drain();
    $display("covered %0d items in, %0d results out, table fill, register extremes",
             n_items, n_results);
    $display("random items mixed table writes and computes over three settings");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
